// ===== design/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and decode functions for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_MOD   = 8'h25;

	typedef enum logic [2:0] {
		OP_END   = 3'd0,
		OP_OPEN  = 3'd1,
		OP_PLUS  = 3'd2,
		OP_MINUS = 3'd3,
		OP_MUL   = 3'd4,
		OP_DIV   = 3'd5,
		OP_MOD   = 3'd6
	} op_code_t;

	typedef enum logic [1:0] {
		KIND_OPERAND,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_OPER
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNMATCHED = 2'd2
	} error_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_ITEM,
		EMIT_TOP
	} emit_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_expr;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       run_last;
		logic       expr_done;
		logic [1:0] error_code;
	} out_beat_t;

	typedef struct packed {
		logic      accept;
		logic      pop;
		logic      push;
		logic      clear;
		logic      finish;
		emit_sel_t emit;
	} cmd_t;

	typedef struct packed {
		kind_t  kind;
		logic   fin;
		error_t err;
		logic   count_zero;
		logic   top_open;
		logic   top_end;
		logic   top_ge;
		logic   pend_v;
		logic   need_out;
		logic   out_free;
	} status_t;

	function automatic kind_t kind_of(logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_OPEN:  k = KIND_OPEN;
			CH_CLOSE: k = KIND_CLOSE;
			CH_END, CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_MOD: k = KIND_OPER;
			default:  k = KIND_OPERAND;
		endcase
		return k;
	endfunction

	function automatic op_code_t code_of(logic [7:0] c);
		op_code_t o;
		unique case (c)
			CH_OPEN:  o = OP_OPEN;
			CH_PLUS:  o = OP_PLUS;
			CH_MINUS: o = OP_MINUS;
			CH_MUL:   o = OP_MUL;
			CH_DIV:   o = OP_DIV;
			CH_MOD:   o = OP_MOD;
			default:  o = OP_END;
		endcase
		return o;
	endfunction

	function automatic logic [1:0] prec_of(op_code_t o);
		logic [1:0] p;
		case (o) inside
			OP_PLUS, OP_MINUS:       p = 2'd1;
			OP_MUL, OP_DIV, OP_MOD:  p = 2'd2;
			default:                 p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] char_of(op_code_t o);
		logic [7:0] c;
		unique case (o)
			OP_END:   c = CH_END;
			OP_OPEN:  c = CH_OPEN;
			OP_PLUS:  c = CH_PLUS;
			OP_MINUS: c = CH_MINUS;
			OP_MUL:   c = CH_MUL;
			OP_DIV:   c = CH_DIV;
			OP_MOD:   c = CH_MOD;
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== design/itp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/itp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_datapath
// Operator stack, item registers, pending result and output register.
// ----------------------------------------------------------------------------
module itp_datapath #(
	parameter int STACK_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itp_pkg::in_beat_t in_beat,
	input  itp_pkg::cmd_t     cmd,
	output itp_pkg::status_t  status,
	output logic              out_valid,
	input  logic              out_stall,
	output itp_pkg::out_beat_t out_beat
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]        count_q, count_d, open_q;
	itp_pkg::op_code_t    top_q;
	logic [7:0]           item_char_q;
	itp_pkg::kind_t       item_kind_q;
	itp_pkg::op_code_t    item_code_q;
	logic                 item_fin_q;
	itp_pkg::error_t      item_err_q;
	logic [7:0]           pend_char_q;
	logic                 pend_v_q;
	logic                 out_valid_q;
	itp_pkg::out_beat_t   out_q;

	itp_pkg::kind_t       in_kind;
	itp_pkg::op_code_t    in_code;
	itp_pkg::error_t      in_err;
	logic                 full;
	logic [AW-1:0]        rd_addr;
	logic [2:0]           rd_data;
	logic [7:0]           emit_char;
	logic                 need_out;
	logic                 out_free;
	logic                 load_mid;
	logic                 load_end;

	assign in_kind  = itp_pkg::kind_of(in_beat.in_char);
	assign in_code  = itp_pkg::code_of(in_beat.in_char);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign out_free = !out_valid_q || !out_stall;
	assign need_out = pend_v_q || item_fin_q || (item_err_q != itp_pkg::ERR_NONE);
	assign load_mid = (cmd.emit != itp_pkg::EMIT_NONE) && pend_v_q;
	assign load_end = cmd.finish && need_out;

	always_comb begin
		in_err = itp_pkg::ERR_NONE;
		unique case (in_kind)
			itp_pkg::KIND_OPEN: begin
				if (full) in_err = itp_pkg::ERR_OVERFLOW;
			end
			itp_pkg::KIND_CLOSE: begin
				if (open_q == '0) in_err = itp_pkg::ERR_UNMATCHED;
			end
			itp_pkg::KIND_OPER: begin
				if (full && (itp_pkg::prec_of(top_q) < itp_pkg::prec_of(in_code)))
					in_err = itp_pkg::ERR_OVERFLOW;
			end
			itp_pkg::KIND_OPERAND: begin
				in_err = itp_pkg::ERR_NONE;
			end
		endcase
	end

	always_comb begin
		if (cmd.clear) begin
			count_d = '0;
		end else if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end else if (cmd.push) begin
			count_d = count_q + CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	// prefetch the entry below the next top
	assign rd_addr = AW'(count_d - CW'(2));

	itp_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (item_code_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		unique case (cmd.emit)
			itp_pkg::EMIT_ITEM: emit_char = item_char_q;
			itp_pkg::EMIT_TOP:  emit_char = itp_pkg::char_of(top_q);
			default:            emit_char = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			open_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.clear) begin
				open_q <= '0;
			end else if (cmd.pop && (top_q == itp_pkg::OP_OPEN)) begin
				open_q <= open_q - CW'(1);
			end else if (cmd.push && (item_code_q == itp_pkg::OP_OPEN)) begin
				open_q <= open_q + CW'(1);
			end
			if (cmd.emit != itp_pkg::EMIT_NONE) begin
				pend_v_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
			if (load_mid || load_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			top_q <= itp_pkg::op_code_t'(rd_data);
		end else if (cmd.push) begin
			top_q <= item_code_q;
		end
		if (cmd.accept) begin
			item_char_q <= in_beat.in_char;
			item_kind_q <= in_kind;
			item_code_q <= in_code;
			item_fin_q  <= in_beat.end_of_expr;
			item_err_q  <= in_err;
		end
		if (cmd.emit != itp_pkg::EMIT_NONE) begin
			pend_char_q <= emit_char;
		end
		if (load_mid) begin
			out_q.out_char   <= pend_char_q;
			out_q.char_valid <= 1'b1;
			out_q.run_last   <= 1'b0;
			out_q.expr_done  <= 1'b0;
			out_q.error_code <= item_err_q;
		end else if (load_end) begin
			out_q.out_char   <= pend_v_q ? pend_char_q : 8'h00;
			out_q.char_valid <= pend_v_q;
			out_q.run_last   <= 1'b1;
			out_q.expr_done  <= item_fin_q;
			out_q.error_code <= item_err_q;
		end
	end

	always_comb begin
		status.kind       = item_kind_q;
		status.fin        = item_fin_q;
		status.err        = item_err_q;
		status.count_zero = (count_q == '0);
		status.top_open   = (top_q == itp_pkg::OP_OPEN);
		status.top_end    = (top_q == itp_pkg::OP_END);
		status.top_ge     = itp_pkg::prec_of(top_q) >= itp_pkg::prec_of(item_code_q);
		status.pend_v     = pend_v_q;
		status.need_out   = need_out;
		status.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q < CW'(STACK_DEPTH)))
		else $error("push onto full stack");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop from empty stack");
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= count_q)
		else $error("open count exceeds stack count");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load_mid || load_end) |-> out_free)
		else $error("output register overwritten while stalled");
`endif

endmodule

// ===== design/itp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer for the converter: accept, pop/push steps, flush and finish.
// ----------------------------------------------------------------------------
module itp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  itp_pkg::status_t status,
	output itp_pkg::cmd_t    cmd
);

	itp_pkg::state_t state_q, state_d;
	logic            out_ok;
	logic            done_ok;
	itp_pkg::state_t after_work;

	assign out_ok     = status.out_free || !status.pend_v;
	assign done_ok    = status.out_free || !status.need_out;
	assign after_work = status.fin ? itp_pkg::ST_FLUSH : itp_pkg::ST_FINISH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		cmd        = '0;
		cmd.emit   = itp_pkg::EMIT_NONE;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = itp_pkg::ST_WORK;
				end
			end
			itp_pkg::ST_WORK: begin
				unique case (status.kind)
					itp_pkg::KIND_OPERAND: begin
						if (out_ok) begin
							cmd.emit = itp_pkg::EMIT_ITEM;
							state_d  = after_work;
						end
					end
					itp_pkg::KIND_OPEN: begin
						cmd.push = (status.err == itp_pkg::ERR_NONE);
						state_d  = after_work;
					end
					itp_pkg::KIND_CLOSE: begin
						if (status.count_zero) begin
							state_d = after_work;
						end else if (status.top_open) begin
							cmd.pop = 1'b1;
							state_d = after_work;
						end else if (out_ok) begin
							cmd.pop  = 1'b1;
							cmd.emit = itp_pkg::EMIT_TOP;
						end
					end
					itp_pkg::KIND_OPER: begin
						if (!status.count_zero && status.top_ge) begin
							if (out_ok) begin
								cmd.pop  = 1'b1;
								cmd.emit = itp_pkg::EMIT_TOP;
							end
						end else begin
							cmd.push = (status.err == itp_pkg::ERR_NONE);
							state_d  = after_work;
						end
					end
				endcase
			end
			itp_pkg::ST_FLUSH: begin
				if (!status.count_zero && !status.top_end) begin
					if (out_ok) begin
						cmd.pop  = 1'b1;
						cmd.emit = itp_pkg::EMIT_TOP;
					end
				end else begin
					cmd.clear = 1'b1;
					state_d   = itp_pkg::ST_FINISH;
				end
			end
			itp_pkg::ST_FINISH: begin
				if (done_ok) begin
					cmd.finish = 1'b1;
					in_stall   = 1'b0;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = itp_pkg::ST_WORK;
					end else begin
						state_d = itp_pkg::ST_IDLE;
					end
				end
			end
		endcase
	end

endmodule

// ===== design/infix_to_postfix_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: one infix character per beat in, postfix
// characters out, operators held on a RAM-based stack.
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// infix     input      infix_valid / infix_stall     infix_beat   (in_beat_t)
// postfix   output     postfix_valid / postfix_stall postfix_beat (out_beat_t)
//
// An item is handled as an accept, then one work step; each operator popped
// and emitted adds a step, and an end flag adds a flush step plus one per
// flushed entry, as the single stack RAM read port gives one entry per step and
// the output register takes one beat per step. The finish step overlaps the next accept.
// Reset empties the stack; stack RAM contents are not cleared.
// A stalled output beat holds the sequencer only when another beat must load.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               infix_valid,
	output logic               infix_stall,
	input  itp_pkg::in_beat_t  infix_beat,
	output logic               postfix_valid,
	input  logic               postfix_stall,
	output itp_pkg::out_beat_t postfix_beat
);

	itp_pkg::cmd_t    cmd;
	itp_pkg::status_t status;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (infix_valid),
		.in_stall (infix_stall),
		.status   (status),
		.cmd      (cmd)
	);

	itp_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (infix_beat),
		.cmd       (cmd),
		.status    (status),
		.out_valid (postfix_valid),
		.out_stall (postfix_stall),
		.out_beat  (postfix_beat)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infix-to-postfix converter. Expression
// characters are queued by a stimulus process, driven one beat at a time, and
// every postfix beat is checked against an operator-stack predictor that
// tracks precedence, parentheses, end markers, overflow and unmatched closes.
// ----------------------------------------------------------------------------
module tb;

	localparam int STACK_DEPTH = 32;
	localparam int ITEM_GOAL   = 420;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               infix_valid   = 1'b0;
	logic               infix_stall;
	itp_pkg::in_beat_t  infix_beat    = '0;
	logic               postfix_valid;
	logic               postfix_stall = 1'b0;
	itp_pkg::out_beat_t postfix_beat;

	itp_pkg::in_beat_t  infix_todo[$];
	itp_pkg::out_beat_t postfix_due[$];
	itp_pkg::op_code_t  held_ops[STACK_DEPTH];
	int unsigned op_depth = 0;
	int unsigned staged   = 0;
	int unsigned mismatches = 0;
	int unsigned beats_seen = 0;
	int unsigned cyc = 0;

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.infix_valid  (infix_valid),
		.infix_stall  (infix_stall),
		.infix_beat   (infix_beat),
		.postfix_valid(postfix_valid),
		.postfix_stall(postfix_stall),
		.postfix_beat (postfix_beat)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit lull();
		if (cyc >= 600 && cyc < 1400)
			return 1'b0;
		return $urandom_range(99) < 16;
	endfunction

	function automatic logic [1:0] rank(itp_pkg::op_code_t o);
		case (o)
			itp_pkg::OP_PLUS, itp_pkg::OP_MINUS:                 return 2'd1;
			itp_pkg::OP_MUL, itp_pkg::OP_DIV, itp_pkg::OP_MOD:   return 2'd2;
			default:                                             return 2'd0;
		endcase
	endfunction

	function automatic logic [7:0] glyph(itp_pkg::op_code_t o);
		case (o)
			itp_pkg::OP_END:   return itp_pkg::CH_END;
			itp_pkg::OP_OPEN:  return itp_pkg::CH_OPEN;
			itp_pkg::OP_PLUS:  return itp_pkg::CH_PLUS;
			itp_pkg::OP_MINUS: return itp_pkg::CH_MINUS;
			itp_pkg::OP_MUL:   return itp_pkg::CH_MUL;
			itp_pkg::OP_DIV:   return itp_pkg::CH_DIV;
			itp_pkg::OP_MOD:   return itp_pkg::CH_MOD;
			default:           return 8'h00;
		endcase
	endfunction

	function automatic itp_pkg::op_code_t op_for(logic [7:0] c);
		case (c)
			itp_pkg::CH_PLUS:  return itp_pkg::OP_PLUS;
			itp_pkg::CH_MINUS: return itp_pkg::OP_MINUS;
			itp_pkg::CH_MUL:   return itp_pkg::OP_MUL;
			itp_pkg::CH_DIV:   return itp_pkg::OP_DIV;
			itp_pkg::CH_MOD:   return itp_pkg::OP_MOD;
			itp_pkg::CH_OPEN:  return itp_pkg::OP_OPEN;
			default:           return itp_pkg::OP_END;
		endcase
	endfunction

	function automatic bit is_symbol(logic [7:0] c);
		return c inside {itp_pkg::CH_END, itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE,
			itp_pkg::CH_PLUS, itp_pkg::CH_MINUS, itp_pkg::CH_MUL,
			itp_pkg::CH_DIV, itp_pkg::CH_MOD};
	endfunction

	task automatic push_op(input itp_pkg::op_code_t code, inout itp_pkg::error_t err);
		if (op_depth >= STACK_DEPTH) begin
			err = itp_pkg::ERR_OVERFLOW;
		end else begin
			held_ops[op_depth] = code;
			op_depth++;
		end
	endtask

	task automatic convert_char(input itp_pkg::in_beat_t b);
		logic [7:0]         chars[$];
		itp_pkg::error_t    err;
		itp_pkg::op_code_t  code;
		bit                 matched;
		bit                 bare;
		itp_pkg::out_beat_t r;
		err = itp_pkg::ERR_NONE;
		matched = 1'b0;
		case (b.in_char)
			itp_pkg::CH_OPEN: push_op(itp_pkg::OP_OPEN, err);
			itp_pkg::CH_CLOSE: begin
				while (op_depth > 0 && !matched) begin
					op_depth--;
					if (held_ops[op_depth] == itp_pkg::OP_OPEN)
						matched = 1'b1;
					else
						chars.push_back(glyph(held_ops[op_depth]));
				end
				if (!matched)
					err = itp_pkg::ERR_UNMATCHED;
			end
			itp_pkg::CH_END, itp_pkg::CH_PLUS, itp_pkg::CH_MINUS,
			itp_pkg::CH_MUL, itp_pkg::CH_DIV, itp_pkg::CH_MOD: begin
				code = op_for(b.in_char);
				while (op_depth > 0 && rank(held_ops[op_depth - 1]) >= rank(code)) begin
					op_depth--;
					chars.push_back(glyph(held_ops[op_depth]));
				end
				push_op(code, err);
			end
			default: chars.push_back(b.in_char);
		endcase
		if (b.end_of_expr) begin
			while (op_depth > 0 && held_ops[op_depth - 1] != itp_pkg::OP_END) begin
				op_depth--;
				chars.push_back(glyph(held_ops[op_depth]));
			end
			op_depth = 0;
		end
		bare = (chars.size() == 0);
		if (bare && (b.end_of_expr || err != itp_pkg::ERR_NONE))
			chars.push_back(8'h00);
		foreach (chars[i]) begin
			r.out_char   = chars[i];
			r.char_valid = !bare;
			r.run_last   = (i == chars.size() - 1);
			r.expr_done  = (i == chars.size() - 1) && b.end_of_expr;
			r.error_code = err;
			postfix_due.push_back(r);
		end
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: postfix beat %0d: %s", $realtime, beats_seen, msg);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infix_valid <= 1'b0;
			infix_beat  <= '0;
		end else begin
			cyc <= cyc + 1;
			if (infix_valid && !infix_stall)
				convert_char(infix_beat);
			if (!infix_valid || !infix_stall) begin
				if (infix_todo.size() != 0 && !lull()) begin
					infix_valid <= 1'b1;
					infix_beat  <= infix_todo.pop_front();
				end else begin
					infix_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		itp_pkg::out_beat_t want;
		if (!arst_n) begin
			postfix_stall <= 1'b0;
		end else begin
			if (postfix_valid && !postfix_stall) begin
				if (postfix_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat %h", postfix_beat));
				end else begin
					want = postfix_due.pop_front();
					if (postfix_beat.out_char !== want.out_char)
						flag_mismatch($sformatf("out_char %h, want %h",
							postfix_beat.out_char, want.out_char));
					if (postfix_beat.char_valid !== want.char_valid)
						flag_mismatch($sformatf("char_valid %b, want %b",
							postfix_beat.char_valid, want.char_valid));
					if (postfix_beat.run_last !== want.run_last)
						flag_mismatch($sformatf("run_last %b, want %b",
							postfix_beat.run_last, want.run_last));
					if (postfix_beat.expr_done !== want.expr_done)
						flag_mismatch($sformatf("expr_done %b, want %b",
							postfix_beat.expr_done, want.expr_done));
					if (postfix_beat.error_code !== want.error_code)
						flag_mismatch($sformatf("error_code %0d, want %0d",
							postfix_beat.error_code, want.error_code));
				end
				beats_seen++;
			end
			postfix_stall <= lull();
		end
	end

	task automatic stage(input logic [7:0] c, input logic fin);
		itp_pkg::in_beat_t b;
		b.in_char     = c;
		b.end_of_expr = fin;
		infix_todo.push_back(b);
		staged++;
	endtask

	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (is_symbol(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(11))
			0, 1:    return itp_pkg::CH_PLUS;
			2, 3:    return itp_pkg::CH_MINUS;
			4, 5:    return itp_pkg::CH_MUL;
			6, 7:    return itp_pkg::CH_DIV;
			8, 9:    return itp_pkg::CH_MOD;
			default: return ($urandom_range(2) == 0) ? itp_pkg::CH_END : itp_pkg::CH_PLUS;
		endcase
	endfunction

	task automatic mark_end();
		infix_todo[infix_todo.size() - 1].end_of_expr = 1'b1;
	endtask

	task automatic queue_expression(input int terms, input bit broken);
		int open_n;
		open_n = 0;
		if ($urandom_range(4) == 0)
			stage(itp_pkg::CH_END, 1'b0);
		for (int t = 0; t < terms; t++) begin
			if (t > 0)
				stage(pick_operator(), 1'b0);
			while ($urandom_range(3) == 0 && open_n < 6) begin
				stage(itp_pkg::CH_OPEN, 1'b0);
				open_n++;
			end
			stage(pick_operand(), 1'b0);
			while (open_n > 0 && $urandom_range(2) == 0) begin
				stage(itp_pkg::CH_CLOSE, 1'b0);
				open_n--;
			end
		end
		if (broken) begin
			case ($urandom_range(2))
				0: repeat ($urandom_range(1, 3)) stage(itp_pkg::CH_CLOSE, 1'b0);
				1: stage(pick_operator(), 1'b0);
				default: ;
			endcase
		end else begin
			repeat (open_n) stage(itp_pkg::CH_CLOSE, 1'b0);
		end
		mark_end();
	endtask

	task automatic queue_deep_nest();
		repeat (STACK_DEPTH + $urandom_range(1, 4)) stage(itp_pkg::CH_OPEN, 1'b0);
		stage(pick_operand(), 1'b0);
		if ($urandom_range(1) == 0) begin
			stage(pick_operator(), 1'b0);
			stage(pick_operand(), 1'b0);
		end
		repeat ($urandom_range(0, 5)) stage(itp_pkg::CH_CLOSE, 1'b0);
		stage(pick_operand(), 1'b1);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (infix_todo.size() != 0 || infix_valid || postfix_due.size() != 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// precedence, parentheses and flush
		stage("a", 1'b0);
		stage(itp_pkg::CH_PLUS, 1'b0);
		stage(8'h00, 1'b0);
		stage(itp_pkg::CH_MUL, 1'b0);
		stage(8'hFF, 1'b0);
		stage(itp_pkg::CH_MINUS, 1'b0);
		stage(itp_pkg::CH_DIV, 1'b0);
		stage(itp_pkg::CH_OPEN, 1'b0);
		stage("b", 1'b0);
		stage(itp_pkg::CH_MOD, 1'b0);
		stage("c", 1'b0);
		stage(itp_pkg::CH_CLOSE, 1'b0);
		stage("d", 1'b1);
		// close on an empty stack
		stage(itp_pkg::CH_CLOSE, 1'b0);
		// close that pops a stacked end marker, then runs out
		stage(itp_pkg::CH_END, 1'b0);
		stage("x", 1'b0);
		stage(itp_pkg::CH_PLUS, 1'b0);
		stage("y", 1'b0);
		stage(itp_pkg::CH_CLOSE, 1'b0);
		// end marker as operator pops an open, flush stops below it
		stage(itp_pkg::CH_OPEN, 1'b0);
		stage("p", 1'b0);
		stage(itp_pkg::CH_END, 1'b0);
		stage(itp_pkg::CH_MUL, 1'b0);
		stage("q", 1'b1);
		// bare end beat, then a flushed open
		stage(itp_pkg::CH_END, 1'b1);
		stage(itp_pkg::CH_OPEN, 1'b1);
		settle();

		queue_deep_nest();
		while (staged < ITEM_GOAL) begin
			case ($urandom_range(99)) inside
				[0:69]:  queue_expression($urandom_range(1, 10), 1'b0);
				[70:79]: begin
					repeat ($urandom_range(1, 6))
						stage(8'($urandom_range(255)), 1'($urandom_range(3) == 0));
				end
				[80:95]: queue_expression($urandom_range(1, 6), 1'b1);
				default: queue_deep_nest();
			endcase
			if (staged >= ITEM_GOAL / 2 && staged < ITEM_GOAL / 2 + 12)
				settle();
		end
		stage(pick_operand(), 1'b1);

		settle();
		repeat (48) @(negedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== infix_to_postfix_converter_top.f =====
design/itp_pkg.sv
design/itp_ram.sv
design/itp_datapath.sv
design/itp_ctrl.sv
design/infix_to_postfix_converter_top.sv
tb/sv/tb.sv
